/* rtl/core/rgbpal_pkg.sv */
// rgbpal_pkg: widths, stage records and constant palette tables for the
// rgb to 256-colour palette index block. No dependencies.
package rgbpal_pkg;

	localparam int CH_W       = 8;    // colour and alpha channel width
	localparam int KEEP_W     = 5;    // channel bits kept before expansion
	localparam int KEEP_N     = 32;   // codes of a kept channel
	localparam int IDX_W      = 8;    // palette index width
	localparam int LVL_W      = 3;    // cube level 0..5
	localparam int CUBE_STEP  = 51;
	localparam int CUBE_N     = 216;
	localparam int GRAY_N     = 40;
	localparam int GRAY_W     = 6;    // gray step 0..39
	localparam int CSQ_W      = 10;   // one channel's squared cube error, at most 625
	localparam int CDIST_W    = 11;   // cube distance, at most 1875
	localparam int ESQ_W      = 16;   // one expanded channel squared
	localparam int DIST_W     = 18;   // full distance, at most 195075
	localparam int SUM_W      = 10;   // eR + eG + eB, at most 765
	localparam int GTH_W      = 11;   // gray decision thresholds
	localparam logic [CH_W-1:0] ALPHA_THR_RST = 8'd128;

	typedef logic [KEEP_N-1:0][CH_W-1:0]     exp_tab_t;
	typedef logic [KEEP_N-1:0][LVL_W-1:0]    lvl_tab_t;
	typedef logic [KEEP_N-1:0][CSQ_W-1:0]    csq_tab_t;
	typedef logic [KEEP_N-1:0][ESQ_W-1:0]    esq_tab_t;
	typedef logic [GRAY_N-1:0][CH_W-1:0]     gray_tab_t;
	typedef logic [GRAY_N-1:0][DIST_W-1:0]   g3sq_tab_t;
	typedef logic [GRAY_N-2:0][GTH_W-1:0]    gth_tab_t;

	// expanded channel value floor(v*255/31)
	function automatic exp_tab_t f_exp_tab();
		exp_tab_t t;
		for (int v = 0; v < KEEP_N; v++) begin
			t[v] = CH_W'((v * 255) / 31);
		end
		return t;
	endfunction

	// nearest cube level; the half-way point never falls on an integer
	function automatic lvl_tab_t f_lvl_tab();
		lvl_tab_t t;
		for (int v = 0; v < KEEP_N; v++) begin
			t[v] = LVL_W'((((v * 255) / 31) + 25) / CUBE_STEP);
		end
		return t;
	endfunction

	function automatic csq_tab_t f_csq_tab();
		csq_tab_t t;
		int e;
		int d;
		for (int v = 0; v < KEEP_N; v++) begin
			e = (v * 255) / 31;
			d = e - ((e + 25) / CUBE_STEP) * CUBE_STEP;
			t[v] = CSQ_W'(d * d);
		end
		return t;
	endfunction

	function automatic esq_tab_t f_esq_tab();
		esq_tab_t t;
		int e;
		for (int v = 0; v < KEEP_N; v++) begin
			e = (v * 255) / 31;
			t[v] = ESQ_W'(e * e);
		end
		return t;
	endfunction

	function automatic gray_tab_t f_gray_tab();
		gray_tab_t t;
		for (int k = 0; k < GRAY_N; k++) begin
			t[k] = CH_W'((k * 255) / 39);
		end
		return t;
	endfunction

	function automatic g3sq_tab_t f_g3sq_tab();
		g3sq_tab_t t;
		int g;
		for (int k = 0; k < GRAY_N; k++) begin
			g = (k * 255) / 39;
			t[k] = DIST_W'(3 * g * g);
		end
		return t;
	endfunction

	// step k+1 beats step k when 2*S > 3*(g_k + g_k+1)
	function automatic gth_tab_t f_gth_tab();
		gth_tab_t t;
		for (int k = 0; k < GRAY_N - 1; k++) begin
			t[k] = GTH_W'(3 * (((k * 255) / 39) + (((k + 1) * 255) / 39)));
		end
		return t;
	endfunction

	localparam exp_tab_t  EXP_TAB  = f_exp_tab();
	localparam lvl_tab_t  LVL_TAB  = f_lvl_tab();
	localparam csq_tab_t  CSQ_TAB  = f_csq_tab();
	localparam esq_tab_t  ESQ_TAB  = f_esq_tab();
	localparam gray_tab_t GRAY_TAB = f_gray_tab();
	localparam g3sq_tab_t G3SQ_TAB = f_g3sq_tab();
	localparam gth_tab_t  GTH_TAB  = f_gth_tab();

	typedef struct packed {
		logic [KEEP_W-1:0] v_r;
		logic [KEEP_W-1:0] v_g;
		logic [KEEP_W-1:0] v_b;
		logic              opaque;
	} st1_t;

	typedef struct packed {
		logic [IDX_W-1:0]   cube_idx;
		logic [CDIST_W-1:0] cube_d;
		logic [DIST_W-1:0]  esq;
		logic [SUM_W-1:0]   ssum;
		logic               opaque;
	} st2_t;

	typedef struct packed {
		logic [GRAY_W-1:0]  k;
		logic [IDX_W-1:0]   cube_idx;
		logic [CDIST_W-1:0] cube_d;
		logic [DIST_W-1:0]  esq;
		logic [SUM_W-1:0]   ssum;
		logic               opaque;
	} st3_t;

	typedef struct packed {
		logic [DIST_W-1:0]  gray_d;
		logic [GRAY_W-1:0]  k;
		logic [IDX_W-1:0]   cube_idx;
		logic [CDIST_W-1:0] cube_d;
		logic               opaque;
	} st4_t;

endpackage

/* rtl/core/rgbpal_pix_if.sv */
// rgbpal_pix_if: pixel request channel, valid/ready with an RGBA payload.
// Depends on rgbpal_pkg.
interface rgbpal_pix_if import rgbpal_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] alpha;

	modport source (output valid, output red, output green, output blue, output alpha,
		input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		output ready);
endinterface

/* rtl/core/rgbpal_res_if.sv */
// rgbpal_res_if: result request channel, valid/ready with index and opaque flag.
// Depends on rgbpal_pkg.
interface rgbpal_res_if import rgbpal_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] palette_index;
	logic             opaque;

	modport source (output valid, output palette_index, output opaque, input ready);
	modport sink (input valid, input palette_index, input opaque, output ready);
endinterface

/* rtl/core/rgbpal_chan_map.sv */
// rgbpal_chan_map: per-channel table lookups, nearest cube entry and its
// distance, channel sum and sum of squares. Depends on rgbpal_pkg.
module rgbpal_chan_map import rgbpal_pkg::*; (
	input  logic clk,
	input  logic ld,
	input  st1_t d_s1,
	output st2_t q_s2
);

	st2_t nxt;
	logic [LVL_W-1:0] l_r, l_g, l_b;

	always_comb begin
		l_r = LVL_TAB[d_s1.v_r];
		l_g = LVL_TAB[d_s1.v_g];
		l_b = LVL_TAB[d_s1.v_b];
		// 36r + 6g + b with shifts
		nxt.cube_idx = ({5'd0, l_r} << 5) + ({5'd0, l_r} << 2)
			+ ({5'd0, l_g} << 2) + ({5'd0, l_g} << 1) + {5'd0, l_b};
		nxt.cube_d = {1'b0, CSQ_TAB[d_s1.v_r]} + {1'b0, CSQ_TAB[d_s1.v_g]}
			+ {1'b0, CSQ_TAB[d_s1.v_b]};
		nxt.esq = {2'd0, ESQ_TAB[d_s1.v_r]} + {2'd0, ESQ_TAB[d_s1.v_g]}
			+ {2'd0, ESQ_TAB[d_s1.v_b]};
		nxt.ssum = {2'd0, EXP_TAB[d_s1.v_r]} + {2'd0, EXP_TAB[d_s1.v_g]}
			+ {2'd0, EXP_TAB[d_s1.v_b]};
		nxt.opaque = d_s1.opaque;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			q_s2 <= nxt;
		end
	end

endmodule

/* rtl/core/rgbpal_gray_find.sv */
// rgbpal_gray_find: picks the nearest gray step from the channel sum alone,
// by comparing twice the sum against the midpoint thresholds. Depends on rgbpal_pkg.
module rgbpal_gray_find import rgbpal_pkg::*; (
	input  logic clk,
	input  logic ld,
	input  st2_t d_s2,
	output st3_t q_s3
);

	logic [GRAY_N-2:0] above;
	logic [GTH_W-1:0]  sum2;
	st3_t nxt;

	always_comb begin
		sum2 = {d_s2.ssum, 1'b0};
		for (int j = 0; j < GRAY_N - 1; j++) begin
			above[j] = sum2 > GTH_TAB[j];
		end
		// thresholds rise with the step, so the count is the step
		nxt.k        = GRAY_W'($countones(above));
		nxt.cube_idx = d_s2.cube_idx;
		nxt.cube_d   = d_s2.cube_d;
		nxt.esq      = d_s2.esq;
		nxt.ssum     = d_s2.ssum;
		nxt.opaque   = d_s2.opaque;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			q_s3 <= nxt;
		end
	end

endmodule

/* rtl/core/rgbpal_gray_dist.sv */
// rgbpal_gray_dist: squared distance to the chosen gray,
// sum(e^2) - 2*g*S + 3*g^2, one 8x10 multiply. Depends on rgbpal_pkg.
module rgbpal_gray_dist import rgbpal_pkg::*; (
	input  logic clk,
	input  logic ld,
	input  st3_t d_s3,
	output st4_t q_s4
);

	logic [CH_W-1:0]        g;
	logic [CH_W+SUM_W-1:0]  prod;
	logic [DIST_W+1:0]      gdist;
	st4_t nxt;

	always_comb begin
		g    = GRAY_TAB[d_s3.k];
		prod = {{SUM_W{1'b0}}, g} * {{CH_W{1'b0}}, d_s3.ssum};
		// never negative, so the low bits are exact
		gdist = {2'd0, d_s3.esq} + {2'd0, G3SQ_TAB[d_s3.k]} - {1'b0, prod, 1'b0};
		nxt.gray_d   = gdist[DIST_W-1:0];
		nxt.k        = d_s3.k;
		nxt.cube_idx = d_s3.cube_idx;
		nxt.cube_d   = d_s3.cube_d;
		nxt.opaque   = d_s3.opaque;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			q_s4 <= nxt;
		end
	end

endmodule

/* rtl/core/rgb_to_256_palette_index.sv */
// rgb_to_256_palette_index: RGBA pixel to 256-colour palette index with alpha gate.
// Depends on rgbpal_pkg, rgbpal_pix_if, rgbpal_res_if, rgbpal_chan_map,
// rgbpal_gray_find and rgbpal_gray_dist.
//
//   channel  dir  payload                          handshake
//   pix      in   red, green, blue, alpha          valid/ready
//   res      out  palette_index, opaque            valid/ready
//   cfg      in   cfg_wdata (alpha threshold)      cfg_we, no ready
//
// one pixel per cycle while the result side does not stall; a taken request passes
// through the input register, cube lookup, gray search, gray distance and result register
// reset clears every stage valid and sets the threshold to 128
// a stalled result holds only the stages behind it that are full; empty stages
// keep filling, so bubbles are squeezed out
module rgb_to_256_palette_index import rgbpal_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	rgbpal_pix_if.sink      pix,
	rgbpal_res_if.source    res,
	input  logic            cfg_we,
	input  logic [CH_W-1:0] cfg_wdata
);

	logic [CH_W-1:0]  thr_q;
	logic             v1_q, v2_q, v3_q, v4_q, out_valid_q;
	logic             rdy1, rdy2, rdy3, rdy4, rdy5;
	st1_t             pix_s1;
	st2_t             st_s2;
	st3_t             st_s3;
	st4_t             st_s4;
	logic [IDX_W-1:0] index_q;
	logic             opaque_q;
	logic [IDX_W-1:0] index_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ALPHA_THR_RST;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// each stage may load when it is empty or its contents move on
	assign rdy5 = !out_valid_q || res.ready;
	assign rdy4 = !v4_q || rdy5;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign pix.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= pix.valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy5) out_valid_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			pix_s1.v_r    <= pix.red[CH_W-1 -: KEEP_W];
			pix_s1.v_g    <= pix.green[CH_W-1 -: KEEP_W];
			pix_s1.v_b    <= pix.blue[CH_W-1 -: KEEP_W];
			pix_s1.opaque <= pix.alpha >= thr_q;
		end
	end

	rgbpal_chan_map u_chan_map (
		.clk  (clk),
		.ld   (rdy2),
		.d_s1 (pix_s1),
		.q_s2 (st_s2)
	);

	rgbpal_gray_find u_gray_find (
		.clk  (clk),
		.ld   (rdy3),
		.d_s2 (st_s2),
		.q_s3 (st_s3)
	);

	rgbpal_gray_dist u_gray_dist (
		.clk  (clk),
		.ld   (rdy4),
		.d_s3 (st_s3),
		.q_s4 (st_s4)
	);

	// cube wins a tie, it has the lower index
	always_comb begin
		if (!st_s4.opaque) begin
			index_nxt = '0;
		end else if (st_s4.gray_d < {{(DIST_W-CDIST_W){1'b0}}, st_s4.cube_d}) begin
			index_nxt = IDX_W'(CUBE_N) + {{(IDX_W-GRAY_W){1'b0}}, st_s4.k};
		end else begin
			index_nxt = st_s4.cube_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			index_q  <= index_nxt;
			opaque_q <= st_s4.opaque;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.palette_index = index_q;
	assign res.opaque        = opaque_q;

	a_transparent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.opaque |-> res.palette_index == '0)
		else $error("transparent result with nonzero index");

	a_gray_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q |-> st_s3.k < GRAY_W'(GRAY_N))
		else $error("gray step out of range");

	a_held_stage: assert property (@(posedge clk) disable iff (!arst_n)
		v4_q && !rdy5 |=> v4_q && $stable(st_s4))
		else $error("held stage lost its contents");

endmodule

/* sim/rgb_to_256_palette_index_chk.sv */
// rgb_to_256_palette_index_chk: watches the pixel, result and threshold ports,
// works out each palette index itself and compares it with the block's result.
// Depends on rgbpal_pkg, rgbpal_pix_if and rgbpal_res_if.
module rgb_to_256_palette_index_chk import rgbpal_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	rgbpal_pix_if           pix,
	rgbpal_res_if           res,
	input  logic            cfg_we,
	input  logic [CH_W-1:0] cfg_wdata,
	output int              errors,
	output int              pending,
	output int              checked,
	output int              opaque_seen
);

	typedef struct packed {
		logic [IDX_W-1:0] palette_index;
		logic             opaque;
	} pal_result_t;

	logic [CH_W-1:0] alpha_thr;
	pal_result_t     expected_q[$];
	int              err_n;
	int              chk_n;
	int              opq_n;

	// top bits of the channel stretched back to 0..255
	function automatic int widen_channel(input logic [CH_W-1:0] c);
		return (int'(c[CH_W-1 -: KEEP_W]) * 255) / 31;
	endfunction

	function automatic int squared(input int x);
		return x * x;
	endfunction

	function automatic pal_result_t quantise(input logic [CH_W-1:0] r, g, b, a, thr);
		pal_result_t outcome;
		int er, eg, eb;
		int pr, pg, pb;
		int sq_sum, best_d;
		outcome = '0;
		if (a < thr)
			return outcome;
		er = widen_channel(r);
		eg = widen_channel(g);
		eb = widen_channel(b);
		best_d = 32'h7fff_ffff;
		// strict compare in ascending order keeps the lowest index on a tie
		for (int idx = 0; idx < CUBE_N + GRAY_N; idx++) begin
			if (idx < CUBE_N) begin
				pr = (idx / 36) * CUBE_STEP;
				pg = ((idx / 6) % 6) * CUBE_STEP;
				pb = (idx % 6) * CUBE_STEP;
			end else begin
				pr = ((idx - CUBE_N) * 255) / (GRAY_N - 1);
				pg = pr;
				pb = pr;
			end
			sq_sum = squared(er - pr) + squared(eg - pg) + squared(eb - pb);
			if (sq_sum < best_d) begin
				best_d = sq_sum;
				outcome.palette_index = IDX_W'(idx);
			end
		end
		outcome.opaque = 1'b1;
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pal_result_t want;
		if (!arst_n) begin
			alpha_thr = ALPHA_THR_RST;
			expected_q.delete();
			err_n = 0;
			chk_n = 0;
			opq_n = 0;
		end else begin
			if (pix.valid && pix.ready)
				expected_q.push_back(quantise(pix.red, pix.green, pix.blue, pix.alpha,
					alpha_thr));
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, index %0d opaque %0b", $time,
						res.palette_index, res.opaque);
					err_n++;
				end else begin
					want = expected_q.pop_front();
					chk_n++;
					if (want.opaque)
						opq_n++;
					if (res.palette_index !== want.palette_index) begin
						$display("%0t: palette_index expected %0d actual %0d", $time,
							want.palette_index, res.palette_index);
						err_n++;
					end
					if (res.opaque !== want.opaque) begin
						$display("%0t: opaque expected %0b actual %0b", $time,
							want.opaque, res.opaque);
						err_n++;
					end
				end
			end
			if (cfg_we)
				alpha_thr = cfg_wdata;
		end
		errors      <= err_n;
		pending     <= expected_q.size();
		checked     <= chk_n;
		opaque_seen <= opq_n;
	end

endmodule

/* sim/rgb_to_256_palette_index_tb.sv */
// rgb_to_256_palette_index_tb: drives pixel requests, result stalls and threshold
// writes into the palette index block; checking sits in rgb_to_256_palette_index_chk.
// Depends on rgbpal_pkg, both channel interfaces, the block and the checker.
module rgb_to_256_palette_index_tb import rgbpal_pkg::*; ();

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 100;
	localparam int MAX_WAIT     = 13;
	localparam int DRAIN_CYCLES = 10;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [CH_W-1:0] cfg_wdata;
	int              errors;
	int              pending;
	int              checked;
	int              opaque_seen;
	int              cycle_cnt = 0;
	int              thr_writes = 0;
	bit              tx_idle;
	bit              rx_idle;
	logic [CH_W-1:0] cur_thr;

	rgbpal_pix_if pix();
	rgbpal_res_if res();

	rgb_to_256_palette_index i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rgb_to_256_palette_index_chk i_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix         (pix),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked),
		.opaque_seen (opaque_seen)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	// result side: a random stall after each taken result while rx_idle is set
	initial begin
		int hold;
		hold = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready)
				hold = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
			else if (hold > 0)
				hold--;
			res.ready <= (hold == 0);
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("%0t: cycle limit reached with %0d results outstanding", $time, pending);
		$display("rgb_to_256_palette_index_tb NOT OK");
		$finish;
	end

	function automatic logic [CH_W-1:0] clamp_chan(input int v);
		if (v < 0)
			return '0;
		if (v > 255)
			return '1;
		return CH_W'(v);
	endfunction

	function automatic logic [CH_W-1:0] jitter(input logic [CH_W-1:0] c);
		int d;
		d = $urandom_range(0, 16);
		return clamp_chan(int'(c) + d - 8);
	endfunction

	function automatic logic [CH_W-1:0] pick_alpha();
		int v;
		case ($urandom_range(0, 3))
			0: begin
				// astride the threshold
				v = $urandom_range(0, 2);
				v = int'(cur_thr) + v - 1;
			end
			1: v = $urandom_range(0, 1) ? 255 : 0;
			default: v = $urandom_range(0, 255);
		endcase
		return clamp_chan(v);
	endfunction

	task automatic send_pixel(input logic [CH_W-1:0] r, g, b, a);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.red   <= r;
		pix.green <= g;
		pix.blue  <= b;
		pix.alpha <= a;
		do @(posedge clk); while (!pix.ready);
	endtask

	task automatic send_random();
		logic [CH_W-1:0] r, g, b;
		int lvl;
		r = CH_W'($urandom);
		g = CH_W'($urandom);
		b = CH_W'($urandom);
		case ($urandom_range(0, 9))
			0, 1: begin
				g = r;
				b = r;
			end
			2, 3: begin
				g = jitter(r);
				b = jitter(r);
			end
			4, 5: begin
				// close to cube corners
				lvl = $urandom_range(0, 5);
				r = jitter(CH_W'(lvl * CUBE_STEP));
				lvl = $urandom_range(0, 5);
				g = jitter(CH_W'(lvl * CUBE_STEP));
				lvl = $urandom_range(0, 5);
				b = jitter(CH_W'(lvl * CUBE_STEP));
			end
			default: ;
		endcase
		send_pixel(r, g, b, pick_alpha());
	endtask

	// stop sending and wait until every request has its result
	task automatic settle();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [CH_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_thr = v;
		thr_writes++;
	endtask

	initial begin
		logic [CH_W-1:0] thr;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		pix.valid <= 1'b0;
		pix.red   <= '0;
		pix.green <= '0;
		pix.blue  <= '0;
		pix.alpha <= '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		cur_thr = ALPHA_THR_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// threshold still at its reset value
		send_pixel(8'h00, 8'h00, 8'h00, 8'd128);
		send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel(8'hff, 8'h00, 8'h00, 8'd200);
		send_pixel(8'h00, 8'hff, 8'h00, 8'd200);
		send_pixel(8'h00, 8'h00, 8'hff, 8'd200);
		send_pixel(8'hff, 8'hff, 8'hff, 8'd127);
		send_pixel(8'h07, 8'h07, 8'h07, 8'hff);
		send_pixel(8'hf8, 8'h80, 8'h08, 8'hff);
		send_pixel(8'h80, 8'h80, 8'h80, 8'hff);
		send_pixel(8'h88, 8'h80, 8'h78, 8'hff);
		send_pixel(8'h33, 8'h66, 8'h99, 8'hff);
		send_pixel(8'h10, 8'h10, 8'h18, 8'hff);
		send_pixel(8'haa, 8'h55, 8'hff, 8'h00);
		// zero threshold, so even alpha 0 is opaque
		set_threshold(8'd0);
		send_pixel(8'h5a, 8'ha5, 8'h3c, 8'h00);
		send_pixel(8'hff, 8'h00, 8'hff, 8'h00);
		set_threshold(8'd255);
		send_pixel(8'h40, 8'hc0, 8'h20, 8'd254);
		send_pixel(8'h40, 8'hc0, 8'h20, 8'd255);
		send_pixel(8'hff, 8'hff, 8'hff, 8'd254);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: thr = 8'd0;
				1: thr = 8'd255;
				2: thr = 8'd1;
				4: thr = ALPHA_THR_RST;
				5: thr = 8'd254;
				default: thr = CH_W'($urandom_range(2, 253));
			endcase
			set_threshold(thr);
			tx_idle = (p % 4 != 1);
			rx_idle = (p % 4 != 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_random();
				if ($urandom_range(0, 63) == 0)
					settle();
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d pixels checked (%0d opaque) over %0d alpha thresholds in %0d cycles",
			checked, opaque_seen, thr_writes + 1, cycle_cnt);
		if (errors == 0)
			$display("rgb_to_256_palette_index_tb OK");
		else
			$display("rgb_to_256_palette_index_tb NOT OK");
		$finish;
	end

endmodule
